// ===== hdl/lbt_pkg.sv =====
// Shared types and constants for the LRU block tracker.
// Used by lru_block_tracker, lbt_cfg_regs and lbt_checker; depends on nothing.
`default_nettype none

package lbt_pkg;

    // Default sizing of the tracker.
    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 32;

    // Field widths of the stream beats.
    localparam int FUNC_W     = 2;
    localparam int ID_FIELD_W = 32;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = ID_FIELD_W;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - (ID_FIELD_W + 1 + OCC_W);

    // Result beat bit positions in tdata.
    localparam int M_TRACKED_BIT = ID_FIELD_W;
    localparam int M_OCC_LSB     = ID_FIELD_W + 1;

    // Configuration port.
    localparam int                 CFG_W           = 5;
    localparam int                 APB_AW          = 3;
    localparam int                 APB_DW          = 32;
    localparam logic [CFG_W-1:0]   MAX_ENTRIES_RST = 5'd16;
    localparam logic [APB_AW-3:0]  REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TOUCH  = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TRIM   = 2'd2
    } t_func;

endpackage

`default_nettype wire

// ===== hdl/lbt_cfg_regs.sv =====
// APB register slice of the LRU block tracker: holds the max_entries limit.
// Depends on lbt_pkg.
`default_nettype none

module lbt_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lbt_pkg::APB_AW-1:0]         paddr,
    input  wire logic [lbt_pkg::APB_DW-1:0]         pwdata,
    output logic      [lbt_pkg::APB_DW-1:0]         prdata,
    output logic                                    pready,
    output logic      [lbt_pkg::CFG_W-1:0]          o_max_entries
);

    logic [lbt_pkg::CFG_W-1:0] r_max_entries;
    logic                      sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[lbt_pkg::APB_AW-1:2] == lbt_pkg::REG_MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= lbt_pkg::MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            r_max_entries <= pwdata[lbt_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max) begin
            prdata = lbt_pkg::APB_DW'(r_max_entries);
        end
    end

    assign o_max_entries = r_max_entries;

endmodule

`default_nettype wire

// ===== hdl/lru_block_tracker.sv =====
// Touch and remove scan the list in S_SCAN and then give their single result beat from S_DONE;
// trim gives one beat per cycle per eviction while m_axis_tready does not stall the output.
// One item is in work at a time; the linear scan of the id memory (one entry per
// cycle through its single read port) sets the rate.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
`default_nettype none

module lru_block_tracker #(
    parameter int DEPTH    = lbt_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = lbt_pkg::ID_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input beat: tdata holds id [31:0]; tuser holds func [1:0].
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [lbt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic [lbt_pkg::FUNC_W-1:0]        s_axis_tuser,
    // Result beat: tdata holds evicted_id [31:0], was_tracked [32],
    // occupancy [37:33], zero pad [39:38]; tuser holds evicted_valid [0].
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [lbt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lbt_pkg::APB_AW-1:0]        paddr,
    input  wire logic [lbt_pkg::APB_DW-1:0]        pwdata,
    output logic      [lbt_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IDW  = (ID_WIDTH < lbt_pkg::ID_FIELD_W) ? ID_WIDTH : lbt_pkg::ID_FIELD_W;
    localparam int CMPW = (CW > lbt_pkg::CFG_W) ? CW : lbt_pkg::CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_DONE
    } t_state;

    // The memory holds the ids in recency order: position 0 is the most
    // recent, position r_count-1 the oldest.
    logic [IDW-1:0]              r_mem [DEPTH];
    logic [IDW-1:0]              r_rd_data;

    t_state                      r_state, n_state;
    logic [lbt_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [IDW-1:0]              r_id, n_id;
    logic [IDW-1:0]              r_carry, n_carry;
    logic [CW-1:0]               r_k, n_k;
    logic                        r_found, n_found;
    logic [CW-1:0]               r_count, n_count;
    logic [IDW-1:0]              r_res_ev_id, n_res_ev_id;
    logic                        r_res_ev, n_res_ev;
    logic                        r_res_tracked, n_res_tracked;

    logic                        r_m_valid, n_m_valid;
    logic [IDW-1:0]              r_m_ev_id, n_m_ev_id;
    logic                        r_m_ev, n_m_ev;
    logic                        r_m_tracked, n_m_tracked;
    logic [lbt_pkg::OCC_W-1:0]   r_m_occ, n_m_occ;
    logic                        r_m_last, n_m_last;

    logic                        rd_en, wr_en;
    logic [AW-1:0]               rd_addr, wr_addr;
    logic [IDW-1:0]              wr_data;

    logic [lbt_pkg::CFG_W-1:0]   max_entries;
    logic                        s_acc, out_free, hit, at_end, over, over_m1;
    logic [CW-1:0]               k_p1, k_m1, cnt_m1, cnt_m2;
    logic [IDW-1:0]              in_id;
    logic [lbt_pkg::FUNC_W-1:0]  in_func;

    lbt_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_entries (max_entries)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign in_func       = s_axis_tuser;
    assign in_id         = s_axis_tdata[0 +: IDW];

    assign k_p1    = r_k + CW'(1);
    assign k_m1    = r_k - CW'(1);
    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign hit     = (r_rd_data == r_id);
    assign at_end  = (r_k == r_count);
    assign over    = CMPW'(r_count) > CMPW'(max_entries);
    assign over_m1 = CMPW'(cnt_m1) > CMPW'(max_entries);

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_id          = r_id;
        n_carry       = r_carry;
        n_k           = r_k;
        n_found       = r_found;
        n_count       = r_count;
        n_res_ev_id   = r_res_ev_id;
        n_res_ev      = r_res_ev;
        n_res_tracked = r_res_tracked;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_ev_id     = r_m_ev_id;
        n_m_ev        = r_m_ev;
        n_m_tracked   = r_m_tracked;
        n_m_occ       = r_m_occ;
        n_m_last      = r_m_last;
        rd_en         = 1'b0;
        rd_addr       = k_p1[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = r_k[AW-1:0];
        wr_data       = r_carry;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_func        = in_func;
                    n_id          = in_id;
                    n_carry       = in_id;
                    n_k           = '0;
                    n_found       = 1'b0;
                    n_res_ev_id   = '0;
                    n_res_ev      = 1'b0;
                    n_res_tracked = 1'b0;
                    case (lbt_pkg::t_func'(in_func))
                        lbt_pkg::FUNC_TOUCH, lbt_pkg::FUNC_REMOVE: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_SCAN;
                        end
                        lbt_pkg::FUNC_TRIM: begin
                            if (over) begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1[AW-1:0];
                                n_state = S_TRIM;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (at_end) begin
                    n_state = S_DONE;
                    if (r_func == lbt_pkg::FUNC_TOUCH) begin
                        // Miss: the carried id lands at the tail, or, when the
                        // list is full, the old tail falls out as the eviction.
                        if (r_count < CW'(DEPTH)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_res_ev    = 1'b1;
                            n_res_ev_id = r_carry;
                        end
                    end else if (r_found) begin
                        n_count       = cnt_m1;
                        n_res_tracked = 1'b1;
                    end
                end else if (r_func == lbt_pkg::FUNC_TOUCH) begin
                    // Move to front: each entry is shifted one place older
                    // until the touched id is met.
                    wr_en   = 1'b1;
                    n_carry = r_rd_data;
                    if (hit) begin
                        n_res_tracked = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        n_k   = k_p1;
                        rd_en = 1'b1;
                    end
                end else begin
                    // Removal closes the gap by shifting older entries up.
                    rd_en = 1'b1;
                    n_k   = k_p1;
                    if (r_found) begin
                        wr_en   = 1'b1;
                        wr_addr = k_m1[AW-1:0];
                        wr_data = r_rd_data;
                    end else if (hit) begin
                        n_found = 1'b1;
                    end
                end
            end

            S_TRIM: begin
                if (out_free) begin
                    n_m_valid   = 1'b1;
                    n_m_ev_id   = r_rd_data;
                    n_m_ev      = 1'b1;
                    n_m_tracked = 1'b0;
                    n_m_occ     = lbt_pkg::OCC_W'(cnt_m1);
                    n_m_last    = !over_m1;
                    n_count     = cnt_m1;
                    if (over_m1) begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m2[AW-1:0];
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_m_valid   = 1'b1;
                    n_m_ev_id   = r_res_ev_id;
                    n_m_ev      = r_res_ev;
                    n_m_tracked = r_res_tracked;
                    n_m_occ     = lbt_pkg::OCC_W'(r_count);
                    n_m_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_id          <= n_id;
        r_carry       <= n_carry;
        r_k           <= n_k;
        r_found       <= n_found;
        r_res_ev_id   <= n_res_ev_id;
        r_res_ev      <= n_res_ev;
        r_res_tracked <= n_res_tracked;
        r_m_ev_id     <= n_m_ev_id;
        r_m_ev        <= n_m_ev;
        r_m_tracked   <= n_m_tracked;
        r_m_occ       <= n_m_occ;
        r_m_last      <= n_m_last;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_ev;
    assign m_axis_tdata  = {{lbt_pkg::M_PAD_W{1'b0}}, r_m_occ, r_m_tracked,
                            lbt_pkg::ID_FIELD_W'(r_m_ev_id)};

endmodule

`default_nettype wire

// ===== hdl/lbt_checker.sv =====
// Port-level checks for lru_block_tracker, attached by the bind at the end.
// Depends on lbt_pkg.
`default_nettype none

module lbt_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lbt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                           m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    logic ev_valid, tracked;

    assign ev_valid = m_axis_tuser;
    assign tracked  = m_axis_tdata[lbt_pkg::M_TRACKED_BIT];

    // One item is worked at a time, so an accepted beat closes the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // A result never reports both a hit and an eviction, and an empty eviction is zero.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(ev_valid && tracked) &&
            (ev_valid || (m_axis_tdata[lbt_pkg::ID_FIELD_W-1:0] == '0)))
        else $error("inconsistent result flags");

    // Only trim runs produce more than one beat, and each of those evicts.
    a_run_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> ev_valid)
        else $error("non-final beat without an eviction");

endmodule

bind lru_block_tracker lbt_checker u_lbt_checker (.*);

`default_nettype wire
